// ===== rtl/base58_encoder_defines.svh =====
// ---------------------------------------------------------------------------
// base58_encoder_defines.svh
// Assertion macros shared by the base58 encoder RTL.
// ---------------------------------------------------------------------------
`ifndef BASE58_ENCODER_DEFINES_SVH
`define BASE58_ENCODER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define B58E_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define B58E_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/b58e_pkg.sv =====
// ---------------------------------------------------------------------------
// b58e_pkg
// Types, constants and the alphabet lookup for the base58 encoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package b58e_pkg;

    // Input beat: one message byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_b58e_in;

    // Output beat: one encoded character
    typedef struct packed {
        logic [6:0] char_code;
        logic       last_char;
        logic       too_long;
    } t_b58e_out;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_EXT,
        ST_PRIME,
        ST_EMIT_Z,
        ST_EMIT_D
    } t_b58e_state;

    localparam int unsigned RADIX      = 58;
    localparam int unsigned DIGIT_W    = 6;
    localparam int unsigned CARRY_W    = 9;   // carry never exceeds 256
    localparam int unsigned VALUE_W    = 14;  // digit * 256 + carry < 16384
    // floor(v / 58) == (v * RECIP_MUL) >> RECIP_SHIFT for v < 16384
    localparam int unsigned RECIP_MUL   = 1130;
    localparam int unsigned RECIP_SHIFT = 16;
    localparam int unsigned RECIP_W     = 11;
    localparam logic [6:0]  CHAR_ONE    = 7'h31;

    localparam logic [6:0] ALPHABET [RADIX] = '{
        7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
        7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h4A,
        7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h50, 7'h51, 7'h52, 7'h53, 7'h54,
        7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A,
        7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67, 7'h68, 7'h69,
        7'h6A, 7'h6B, 7'h6D, 7'h6E, 7'h6F, 7'h70, 7'h71, 7'h72, 7'h73,
        7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7A
    };

    // Digit to ASCII; codes past the alphabet map to the first symbol
    function automatic logic [6:0] b58e_char(input logic [DIGIT_W-1:0] digit);
        logic [6:0] code;
        code = CHAR_ONE;
        if (digit < DIGIT_W'(RADIX)) begin
            code = ALPHABET[digit];
        end
        return code;
    endfunction

endpackage

// ===== rtl/b58e_ram.sv =====
// ---------------------------------------------------------------------------
// b58e_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module b58e_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/base58_encoder.sv =====
// Each byte is accepted in idle, folded once over every stored digit, then
//   extended until the carry is zero; a byte beyond MAX_BYTES is only flagged.
// The next byte waits for idle; one divide-by-58 unit on the digit RAM's
//   single read and write ports sets the pace. After the last byte: a prime
//   state, then one character per cycle, registered; results cannot be stalled.
// Reset is synchronous; the digit RAM is not cleared, only the state, counters and flags.
// ---------------------------------------------------------------------------
// base58_encoder
// Byte-serial base58 encoder with a shared mod-58 fold unit over a digit RAM.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "base58_encoder_defines.svh"

module base58_encoder
    import b58e_pkg::*;
#(
    parameter int MAX_BYTES = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_b58e_in  i_data,
    output logic      o_valid,
    output t_b58e_out o_result
);

    localparam int DIGIT_DEPTH = MAX_BYTES * 138 / 100 + 1;
    localparam int AW          = $clog2(DIGIT_DEPTH);
    localparam int CW          = $clog2(DIGIT_DEPTH + 1);
    localparam int BW          = $clog2(MAX_BYTES + 1);
    localparam int PW          = VALUE_W + RECIP_W;

    t_b58e_state r_state, n_state;

    logic [CW-1:0]      r_dcnt;      // valid digits
    logic [BW-1:0]      r_zcnt;      // leading zero bytes
    logic [BW-1:0]      r_bytes;     // bytes folded this message
    logic               r_in_zp;
    logic               r_ovf;
    logic               r_last;
    logic [CARRY_W-1:0] r_carry;
    logic [AW-1:0]      r_idx;

    logic               r_valid;
    t_b58e_out          r_result;
    logic               n_valid;
    t_b58e_out          n_result;

    // RAM port signals
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [DIGIT_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [DIGIT_W-1:0] ram_rdata;

    // Shared divide-by-58 unit
    logic [VALUE_W-1:0] div_in;
    logic [PW-1:0]      div_prod;
    logic [CARRY_W-1:0] div_q;
    logic [VALUE_W-1:0] div_qx58;
    logic [DIGIT_W-1:0] div_r;

    logic accept;
    logic fold_ok;
    logic fold_end;
    logic ext_go;
    logic msg_done;

    assign accept   = start && !busy;
    assign fold_ok  = r_bytes < BW'(MAX_BYTES);
    assign fold_end = (CW'(r_idx) + CW'(1)) == r_dcnt;
    assign ext_go   = (r_carry != '0) && (r_dcnt < CW'(DIGIT_DEPTH));

    b58e_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DIGIT_DEPTH)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Value into the fold unit: digit*256 + carry while folding, carry alone on extension
    always_comb begin
        if (r_state == ST_FOLD) begin
            div_in = {ram_rdata, 8'h00} + VALUE_W'(r_carry);
        end else begin
            div_in = VALUE_W'(r_carry);
        end
    end

    // Quotient by reciprocal, remainder by shift-add back-multiply
    assign div_prod = PW'(div_in) * PW'(RECIP_MUL);
    assign div_q    = CARRY_W'(div_prod >> RECIP_SHIFT);
    assign div_qx58 = (VALUE_W'(div_q) << 6) - (VALUE_W'(div_q) << 2)
                    - (VALUE_W'(div_q) << 1);
    assign div_r    = DIGIT_W'(div_in - div_qx58);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (fold_ok) begin
                        n_state = (r_dcnt == '0) ? ST_EXT : ST_FOLD;
                    end else if (i_data.last_byte) begin
                        n_state = ST_PRIME;
                    end
                end
            end
            ST_FOLD: begin
                if (fold_end) begin
                    n_state = ST_EXT;
                end
            end
            ST_EXT: begin
                if (!ext_go) begin
                    n_state = r_last ? ST_PRIME : ST_IDLE;
                end
            end
            ST_PRIME: begin
                if (r_zcnt != '0) begin
                    n_state = ST_EMIT_Z;
                end else if (r_dcnt != '0) begin
                    n_state = ST_EMIT_D;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT_Z: begin
                if (r_zcnt == BW'(1)) begin
                    n_state = (r_dcnt != '0) ? ST_EMIT_D : ST_IDLE;
                end
            end
            ST_EMIT_D: begin
                if (r_dcnt == CW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // RAM controls and result beat
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = div_r;
        ram_raddr = '0;
        n_valid   = 1'b0;
        n_result  = '{char_code: CHAR_ONE, last_char: 1'b0, too_long: r_ovf};
        case (r_state)
            ST_IDLE: begin
                ram_raddr = '0;
            end
            ST_FOLD: begin
                ram_we    = 1'b1;
                ram_raddr = fold_end ? '0 : AW'(r_idx + AW'(1));
            end
            ST_EXT: begin
                ram_we    = ext_go;
                ram_waddr = AW'(r_dcnt);
            end
            ST_PRIME, ST_EMIT_Z: begin
                ram_raddr = (r_dcnt == '0) ? '0 : AW'(r_dcnt - CW'(1));
                if (r_state == ST_EMIT_Z) begin
                    n_valid            = 1'b1;
                    n_result.last_char = (r_zcnt == BW'(1)) && (r_dcnt == '0);
                end
            end
            ST_EMIT_D: begin
                ram_raddr = (r_dcnt < CW'(2)) ? '0 : AW'(r_dcnt - CW'(2));
                n_valid            = 1'b1;
                n_result.char_code = b58e_char(ram_rdata);
                n_result.last_char = (r_dcnt == CW'(1));
            end
            default: begin
                ram_raddr = '0;
            end
        endcase
    end

    // State, counters and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dcnt  <= '0;
            r_zcnt  <= '0;
            r_bytes <= '0;
            r_in_zp <= 1'b1;
            r_ovf   <= 1'b0;
            r_last  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_last <= i_data.last_byte;
                        if (fold_ok) begin
                            r_bytes <= r_bytes + BW'(1);
                            if (r_in_zp && (i_data.data_byte == 8'h00)) begin
                                r_zcnt <= r_zcnt + BW'(1);
                            end else begin
                                r_in_zp <= 1'b0;
                            end
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                ST_EXT: begin
                    if (ext_go) begin
                        r_dcnt <= r_dcnt + CW'(1);
                    end
                end
                ST_EMIT_Z: begin
                    r_zcnt <= r_zcnt - BW'(1);
                end
                ST_EMIT_D: begin
                    r_dcnt <= r_dcnt - CW'(1);
                end
                default: begin
                    r_last <= r_last;
                end
            endcase
            // Message finished: clear the per-message flags
            if (msg_done) begin
                r_bytes <= '0;
                r_in_zp <= 1'b1;
                r_ovf   <= 1'b0;
            end
        end
    end

    assign msg_done = (n_state == ST_IDLE) &&
                      ((r_state == ST_PRIME) || (r_state == ST_EMIT_Z) ||
                       (r_state == ST_EMIT_D));

    // Carry, digit index and result payload (no reset needed)
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        case (r_state)
            ST_IDLE: begin
                r_carry <= CARRY_W'(i_data.data_byte);
                r_idx   <= '0;
            end
            ST_FOLD: begin
                r_carry <= div_q;
                r_idx   <= AW'(r_idx + AW'(1));
            end
            ST_EXT: begin
                r_carry <= div_q;
            end
            default: begin
                r_carry <= r_carry;
            end
        endcase
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Checks
    `B58E_ASSERT_NOW(a_dcnt_range, 1'b1, r_dcnt <= CW'(DIGIT_DEPTH),
        "digit count overflow")
    `B58E_ASSERT_NOW(a_bytes_range, 1'b1, r_bytes <= BW'(MAX_BYTES),
        "byte count overflow")
    `B58E_ASSERT_NEXT(a_emit_strobe,
        (r_state == ST_EMIT_Z) || (r_state == ST_EMIT_D), o_valid,
        "emit without strobe")
    `B58E_ASSERT_NOW(a_last_idle, o_valid && o_result.last_char,
        r_state == ST_IDLE, "not idle after last char")
    `B58E_ASSERT_NOW(a_fold_carry, r_state == ST_FOLD,
        r_carry <= CARRY_W'(256), "fold carry too large")

endmodule
